// ===== rtl/bsc_pkg.sv =====
// Package for the bag similarity block: request and result types, codes, sizes.
// No dependencies.
`default_nettype none
package bsc_pkg;
    localparam int DISTINCT_SYMBOLS_DEF = 256;
    localparam int SYMBOL_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [1:0] OP_X = 2'd0;
    localparam logic [1:0] OP_Y = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [2:0] K_JACCARD = 3'd0;
    localparam logic [2:0] K_SIMPSON = 3'd1;
    localparam logic [2:0] K_BRAUN = 3'd2;
    localparam logic [2:0] K_DICE = 3'd3;
    localparam logic [2:0] K_SOKAL = 3'd4;
    localparam logic [2:0] K_KULCZ = 3'd5;
    localparam logic [2:0] K_OTSUKA = 3'd6;

    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_BINARY = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] symbol;
    } request_t;

    typedef struct packed {
        logic [16:0] coefficient;
        logic [15:0] shared_count;
        logic [15:0] only_in_x;
        logic [15:0] only_in_y;
        logic        overflow;
    } result_t;
endpackage
`default_nettype wire

// ===== rtl/bsc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/bag_similarity_coefficients.sv =====
// Bag similarity coefficients: symbol table, table walk, and a shared
// shift-subtract divider and square root unit. Uses bsc_pkg and bsc_ram.
// A symbol request reads and compares one table entry at a time until it matches or passes the used entries.
// A finish walks the table, then runs at most one 64-step division and, for Otsuka, a 32-step root;
// one request at a time, none accepted while a result waits.
// Reset clears the fill count, overflow flag, state, configuration and output valid; the table needs no sweep.
`default_nettype none
module bag_similarity_coefficients
    import bsc_pkg::*;
#(
    parameter int DISTINCT_SYMBOLS = DISTINCT_SYMBOLS_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire request_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_data,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic [2:0] cfg_data
);
    localparam int AW = $clog2(DISTINCT_SYMBOLS);
    localparam int UW = AW + 1;
    localparam int EW = SYMBOL_BITS + 2 * COUNT_BITS;
    localparam int SW = COUNT_BITS + UW;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SRD    = 12'b000000000010,
        S_SCMP   = 12'b000000000100,
        S_WRD    = 12'b000000001000,
        S_WACC   = 12'b000000010000,
        S_CLAMP  = 12'b000000100000,
        S_PREP   = 12'b000001000000,
        S_DIV    = 12'b000010000000,
        S_KMUL   = 12'b000100000000,
        S_SQRT   = 12'b001000000000,
        S_FIN    = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] kind_reg;
    logic binary_reg;
    logic [UW-1:0] used_reg, used_next;
    logic ovf_reg, ovf_next;
    logic [UW-1:0] idx_reg, idx_next;
    request_t req_reg, req_next;
    logic [SW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [63:0] num_reg, num_next, den_reg, den_next, rem_reg, rem_next;
    logic [63:0] q_reg, q_next, keep_reg, keep_next;
    logic [6:0] step_reg, step_next;
    logic [16:0] coef_reg, coef_next;
    logic rovf_reg, rovf_next;
    logic out_valid_reg, out_valid_next;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [SYMBOL_BITS-1:0] e_sym, r_sym;
    logic [COUNT_BITS-1:0] e_cx, e_cy;

    bsc_ram #(.WIDTH(EW), .DEPTH(DISTINCT_SYMBOLS)) u_table (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign e_sym = ram_rdata[EW-1 -: SYMBOL_BITS];
    assign e_cx = ram_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
    assign e_cy = ram_rdata[COUNT_BITS-1:0];
    assign r_sym = SYMBOL_BITS'({32'd0, req_reg.symbol});
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    function automatic logic [15:0] clamp16(input logic [SW-1:0] v);
        return (v > SW'(16'hFFFF)) ? 16'hFFFF : 16'(v);
    endfunction

    logic [63:0] sub_try;
    logic [63:0] rt_try;
    logic [15:0] ca, cb, cc;
    logic [17:0] ab, ac;

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        req_next = req_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        keep_next = keep_reg;
        step_next = step_reg;
        coef_next = coef_reg;
        rovf_next = rovf_reg;
        out_valid_next = out_valid_reg;
        ram_we = 1'b0;
        ram_addr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ca = a_reg[15:0];
        cb = b_reg[15:0];
        cc = c_reg[15:0];
        ab = {2'd0, ca} + {2'd0, cb};
        ac = {2'd0, ca} + {2'd0, cc};
        sub_try = {rem_reg[62:0], num_reg[63]} - den_reg;
        rt_try = q_reg + keep_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (in_valid && in_ready)
                begin
                    req_next = in_data;
                    if (in_data.opcode == OP_X || in_data.opcode == OP_Y)
                    begin
                        state_next = S_SRD;
                    end
                    else if (in_data.opcode == OP_FINISH)
                    begin
                        a_next = '0;
                        b_next = '0;
                        c_next = '0;
                        state_next = S_WRD;
                    end
                end
            end
            S_SRD:
            begin
                if (idx_reg >= used_reg)
                begin
                    if (used_reg >= UW'(DISTINCT_SYMBOLS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        ram_wdata = {r_sym,
                            COUNT_BITS'(req_reg.opcode == OP_X),
                            COUNT_BITS'(req_reg.opcode == OP_Y)};
                        used_next = used_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (e_sym == r_sym)
                begin
                    if (req_reg.opcode == OP_Y)
                    begin
                        if (e_cy == CNT_MAX) ovf_next = 1'b1;
                        else ram_wdata = {e_sym, e_cx, e_cy + 1'b1};
                    end
                    else
                    begin
                        if (e_cx == CNT_MAX) ovf_next = 1'b1;
                        else ram_wdata = {e_sym, e_cx + 1'b1, e_cy};
                    end
                    ram_we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_WRD:
            begin
                state_next = (idx_reg >= used_reg) ? S_CLAMP : S_WACC;
            end
            S_WACC:
            begin
                if (binary_reg)
                begin
                    if (e_cx != 0 && e_cy != 0) a_next = a_reg + 1'b1;
                    else if (e_cx != 0) b_next = b_reg + 1'b1;
                    else if (e_cy != 0) c_next = c_reg + 1'b1;
                end
                else if (e_cx > e_cy)
                begin
                    a_next = a_reg + SW'(e_cy);
                    b_next = b_reg + SW'(e_cx - e_cy);
                end
                else
                begin
                    a_next = a_reg + SW'(e_cx);
                    c_next = c_reg + SW'(e_cy - e_cx);
                end
                idx_next = idx_reg + 1'b1;
                state_next = S_WRD;
            end
            S_CLAMP:
            begin
                rovf_next = ovf_reg || a_reg > SW'(16'hFFFF) || b_reg > SW'(16'hFFFF)
                    || c_reg > SW'(16'hFFFF);
                a_next = SW'(clamp16(a_reg));
                b_next = SW'(clamp16(b_reg));
                c_next = SW'(clamp16(c_reg));
                state_next = S_PREP;
            end
            S_PREP:
            begin
                rem_next = '0;
                q_next = '0;
                step_next = '0;
                coef_next = '0;
                state_next = S_DIV;
                if (kind_reg > K_OTSUKA)
                begin
                    state_next = S_FIN;
                end
                else if (cb == 0 && cc == 0)
                begin
                    coef_next = 17'h10000;
                    state_next = S_FIN;
                end
                else
                begin
                    unique case (kind_reg)
                        K_JACCARD:
                        begin
                            num_next = {32'd0, ca, 16'd0};
                            den_next = 64'(ca) + 64'(cb) + 64'(cc);
                        end
                        K_SIMPSON:
                        begin
                            num_next = {32'd0, ca, 16'd0};
                            den_next = 64'((ab < ac) ? ab : ac);
                        end
                        K_BRAUN:
                        begin
                            num_next = {32'd0, ca, 16'd0};
                            den_next = 64'((ab > ac) ? ab : ac);
                        end
                        K_DICE:
                        begin
                            num_next = {31'd0, ca, 17'd0};
                            den_next = 64'({ca, 1'b0}) + 64'(cb) + 64'(cc);
                        end
                        K_SOKAL:
                        begin
                            num_next = {32'd0, ca, 16'd0};
                            den_next = 64'(ca) + 64'({cb, 1'b0}) + 64'({cc, 1'b0});
                        end
                        default:
                        begin
                            if (ca == 0) state_next = S_FIN;
                            else
                            begin
                                num_next = 64'(ca) * 64'(ab + ac);
                                den_next = 64'(ab) * 64'(ac);
                                state_next = S_KMUL;
                            end
                        end
                    endcase
                    if (kind_reg == K_OTSUKA && ca != 0)
                    begin
                        num_next = 64'(ca) * 64'(ca);
                        den_next = 64'(ab) * 64'(ac);
                        state_next = S_KMUL;
                    end
                end
            end
            S_KMUL:
            begin
                if (kind_reg == K_KULCZ)
                begin
                    num_next = {num_reg[47:0], 16'd0};
                    den_next = {den_reg[62:0], 1'b0};
                end
                else
                begin
                    num_next = {num_reg[31:0], 32'd0};
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (den_reg == 0)
                begin
                    q_next = '0;
                    step_next = 7'd64;
                end
                else if (step_reg < 7'd64)
                begin
                    num_next = {num_reg[62:0], 1'b0};
                    if (rem_reg[63] || sub_try <= {rem_reg[62:0], num_reg[63]}
                        && {rem_reg[62:0], num_reg[63]} >= den_reg)
                    begin
                        rem_next = sub_try;
                        q_next = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[62:0], num_reg[63]};
                        q_next = {q_reg[62:0], 1'b0};
                    end
                    step_next = step_reg + 1'b1;
                end
                if (step_reg == 7'd64 || den_reg == 0)
                begin
                    if (kind_reg == K_OTSUKA)
                    begin
                        num_next = q_reg;
                        q_next = '0;
                        keep_next = 64'd1 << 62;
                        step_next = '0;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        coef_next = (q_reg > 64'h10000) ? 17'h10000 : 17'(q_reg);
                        state_next = S_FIN;
                    end
                end
            end
            S_SQRT:
            begin
                if (keep_reg == 0)
                begin
                    coef_next = (q_reg > 64'h10000) ? 17'h10000 : 17'(q_reg);
                    state_next = S_FIN;
                end
                else
                begin
                    if (num_reg >= rt_try)
                    begin
                        num_next = num_reg - rt_try;
                        q_next = (q_reg >> 1) + keep_reg;
                    end
                    else
                    begin
                        q_next = q_reg >> 1;
                    end
                    keep_next = keep_reg >> 2;
                end
            end
            S_FIN:
            begin
                used_next = '0;
                ovf_next = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= K_JACCARD;
            binary_reg <= 1'b0;
            used_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_KIND) kind_reg <= cfg_data;
                else binary_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        keep_reg <= keep_next;
        step_reg <= step_next;
        coef_reg <= coef_next;
        rovf_reg <= rovf_next;
    end

    assign out_data.coefficient = coef_reg;
    assign out_data.shared_count = a_reg[15:0];
    assign out_data.only_in_x = b_reg[15:0];
    assign out_data.only_in_y = c_reg[15:0];
    assign out_data.overflow = rovf_reg;
endmodule
`default_nettype wire
